// ===== hdl/wbt_pkg.sv =====
// Shared types, constants and the arctangent table for the wet-bulb estimator.
// No dependencies.
`default_nettype none
package wbt_pkg;

    localparam int ATAN_STAGES = 16;
    localparam int SQRT_STAGES = 20;

    localparam logic signed [14:0] T_MIN   = -15'sd5120;
    localparam logic signed [14:0] T_MAX   = 15'sd12800;
    localparam logic        [14:0] RH_MIN  = 15'd1280;
    localparam logic        [14:0] RH_MAX  = 15'd25344;
    localparam logic signed [19:0] WB_MIN  = -20'sd8192;
    localparam logic signed [19:0] WB_MAX  = 20'sd16383;
    localparam logic signed [14:0] THR_RST = 15'sd8960;

    localparam logic [23:0] C_SQ_OFS  = 24'd544844;
    localparam logic [21:0] C_A1_MUL  = 22'd2549751;
    localparam logic [18:0] C_A4_MUL  = 19'd387570;
    localparam logic [16:0] C_C4_MUL  = 17'd65740;
    localparam logic [23:0] C_T3_OFS  = 24'd109860;
    localparam logic [27:0] C_BIAS    = 28'd307104;
    localparam logic signed [31:0] CORDIC_X0 = 32'sd65536;

    typedef struct packed {
        logic [22:0] rem;
        logic [19:0] root;
        logic [39:0] rad;
    } t_sqrt;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [19:0] z;
    } t_cordic;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/wet_bulb_temperature_estimator.sv =====
// Wet-bulb temperature estimator, top level: clamp, root chains, multipliers,
// arctangent chains and final sum. Depends on wbt_pkg, wbt_sqrt_cell, wbt_cordic_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries air temperature and relative
//   humidity, both Q7.8. Output channel (o_out_valid / i_out_stall) carries the
//   wet-bulb temperature in Q7.8, the heat-stress flag and the clamp flag.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the stress
//   threshold; write it only while no item is in flight.
//   Pipeline stages from input accept to output valid (1 clamp, 20 root
//   cells, 2 multiply, ATAN_STAGES arctangent cells, 1 product, 1 output).
//   Throughput: one item per cycle unless stalled; every stage is a register.
//   When the output item is stalled the whole pipeline holds and o_in_stall is
//   raised; otherwise items move every cycle, bubbles included.
//   Reset (synchronous, active low) empties the pipeline and sets the
//   threshold to 35.00 degrees C.
`default_nettype none
module wet_bulb_temperature_estimator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [14:0] i_air_temp,
    input  wire logic [14:0] i_rel_humidity,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [14:0]      o_wet_bulb_temp,
    output logic             o_heat_stress,
    output logic             o_input_clamped,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [14:0] i_cfg_stress_threshold
);
    localparam int SQ = wbt_pkg::SQRT_STAGES;
    localparam int CD = wbt_pkg::ATAN_STAGES;

    typedef struct packed {
        logic signed [22:0] t16;
        logic        [22:0] rh16;
        logic               clamp;
    } t_sq_side;

    typedef struct packed {
        logic signed [22:0] t16;
        logic        [19:0] c4;
        logic               clamp;
    } t_cd_side;

    logic w_en;
    logic signed [14:0] r_thr;

    // clamp
    logic signed [14:0] w_t;
    logic        [14:0] w_rh;
    logic               w_cl;

    t_sq_side r_sq_side [0:SQ];
    logic     r_sq_vld  [0:SQ];
    wbt_pkg::t_sqrt w_sq1 [0:SQ];
    wbt_pkg::t_sqrt w_sq2 [0:SQ];
    logic [23:0] w_rad1_hi;

    // multiply stages
    logic               r_m1_vld;
    logic [17:0]        r_m1_a1;
    logic [26:0]        r_m1_r15;
    logic [17:0]        r_m1_a4;
    logic signed [22:0] r_m1_t16;
    logic [22:0]        r_m1_rh16;
    logic               r_m1_cl;
    logic [41:0]        w_a1p;
    logic [42:0]        w_r15p;
    logic [41:0]        w_a4p;

    logic               r_m2_vld;
    logic [19:0]        r_m2_c4;
    logic [17:0]        r_m2_a1;
    logic [17:0]        r_m2_a4;
    logic signed [24:0] r_m2_arg2;
    logic signed [23:0] r_m2_arg3;
    logic signed [22:0] r_m2_t16;
    logic               r_m2_cl;
    logic [43:0]        w_c4p;

    t_cd_side r_cd_side [1:CD];
    logic     r_cd_vld  [1:CD];
    wbt_pkg::t_cordic w_cd1 [0:CD];
    wbt_pkg::t_cordic w_cd2 [0:CD];
    wbt_pkg::t_cordic w_cd3 [0:CD];
    wbt_pkg::t_cordic w_cd4 [0:CD];

    // products
    logic               r_p_vld;
    logic signed [26:0] r_p_t1;
    logic signed [24:0] r_p_t4;
    logic signed [19:0] r_p_z2;
    logic signed [19:0] r_p_z3;
    logic               r_p_cl;
    logic signed [42:0] w_p1;
    logic signed [40:0] w_p4;

    logic signed [27:0] w_sum;
    logic signed [19:0] w_wb;
    logic signed [14:0] w_wb_sat;

    logic               r_out_vld;
    logic [14:0]        r_out_wb;
    logic               r_out_hs;
    logic               r_out_cl;

    assign w_en        = !r_out_vld || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= wbt_pkg::THR_RST;
        end else if (i_cfg_valid) begin
            r_thr <= $signed(i_cfg_stress_threshold);
        end
    end

    always_comb begin
        w_cl = 1'b0;
        w_t  = $signed(i_air_temp);
        w_rh = i_rel_humidity;
        if (w_t < wbt_pkg::T_MIN) begin
            w_t  = wbt_pkg::T_MIN;
            w_cl = 1'b1;
        end
        if (w_t > wbt_pkg::T_MAX) begin
            w_t  = wbt_pkg::T_MAX;
            w_cl = 1'b1;
        end
        if (w_rh < wbt_pkg::RH_MIN) begin
            w_rh = wbt_pkg::RH_MIN;
            w_cl = 1'b1;
        end
        if (w_rh > wbt_pkg::RH_MAX) begin
            w_rh = wbt_pkg::RH_MAX;
            w_cl = 1'b1;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ; k++) r_sq_vld[k] <= 1'b0;
            for (int k = 1; k <= CD; k++) r_cd_vld[k] <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= i_in_valid;
            for (int k = 1; k <= SQ; k++) r_sq_vld[k] <= r_sq_vld[k-1];
            r_m1_vld    <= r_sq_vld[SQ];
            r_m2_vld    <= r_m1_vld;
            r_cd_vld[1] <= r_m2_vld;
            for (int k = 2; k <= CD; k++) r_cd_vld[k] <= r_cd_vld[k-1];
            r_p_vld     <= r_cd_vld[CD];
            r_out_vld   <= r_p_vld;
        end
    end

    // payload side lines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0].t16   <= {w_t, 8'b0};
            r_sq_side[0].rh16  <= {w_rh, 8'b0};
            r_sq_side[0].clamp <= w_cl;
            for (int k = 1; k <= SQ; k++) r_sq_side[k] <= r_sq_side[k-1];
            r_cd_side[1] <= '{t16: r_m2_t16, c4: r_m2_c4, clamp: r_m2_cl};
            for (int k = 2; k <= CD; k++) r_cd_side[k] <= r_cd_side[k-1];
        end
    end

    // square root chains
    assign w_rad1_hi = {1'b0, r_sq_side[0].rh16} + wbt_pkg::C_SQ_OFS;
    assign w_sq1[0]  = '{rem: '0, root: '0, rad: {w_rad1_hi, 16'b0}};
    assign w_sq2[0]  = '{rem: '0, root: '0, rad: {1'b0, r_sq_side[0].rh16, 16'b0}};

    for (genvar k = 0; k < SQ; k++) begin : g_sq
        wbt_sqrt_cell u_sq1 (.i_clk(i_clk), .i_en(w_en), .i_d(w_sq1[k]), .o_d(w_sq1[k+1]));
        wbt_sqrt_cell u_sq2 (.i_clk(i_clk), .i_en(w_en), .i_d(w_sq2[k]), .o_d(w_sq2[k+1]));
    end

    // multiply stage 1
    assign w_a1p  = 42'(w_sq1[SQ].root) * 42'(wbt_pkg::C_A1_MUL) + 42'd8388608;
    assign w_r15p = 43'(r_sq_side[SQ].rh16) * 43'(w_sq2[SQ].root) + 43'd32768;
    assign w_a4p  = 42'(r_sq_side[SQ].rh16) * 42'(wbt_pkg::C_A4_MUL) + 42'd8388608;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_a1   <= w_a1p[41:24];
            r_m1_r15  <= w_r15p[42:16];
            r_m1_a4   <= w_a4p[41:24];
            r_m1_t16  <= r_sq_side[SQ].t16;
            r_m1_rh16 <= r_sq_side[SQ].rh16;
            r_m1_cl   <= r_sq_side[SQ].clamp;
        end
    end

    // multiply stage 2
    assign w_c4p = 44'(r_m1_r15) * 44'(wbt_pkg::C_C4_MUL) + 44'd8388608;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_c4   <= w_c4p[43:24];
            r_m2_a1   <= r_m1_a1;
            r_m2_a4   <= r_m1_a4;
            r_m2_arg2 <= {{2{r_m1_t16[22]}}, r_m1_t16} + {2'b00, r_m1_rh16};
            r_m2_arg3 <= $signed({1'b0, r_m1_rh16} - wbt_pkg::C_T3_OFS);
            r_m2_t16  <= r_m1_t16;
            r_m2_cl   <= r_m1_cl;
        end
    end

    // arctangent chains
    assign w_cd1[0] = '{x: wbt_pkg::CORDIC_X0, y: $signed({14'b0, r_m2_a1}), z: '0};
    assign w_cd2[0] = '{x: wbt_pkg::CORDIC_X0, y: 32'(r_m2_arg2), z: '0};
    assign w_cd3[0] = '{x: wbt_pkg::CORDIC_X0, y: 32'(r_m2_arg3), z: '0};
    assign w_cd4[0] = '{x: wbt_pkg::CORDIC_X0, y: $signed({14'b0, r_m2_a4}), z: '0};

    for (genvar k = 0; k < CD; k++) begin : g_cd
        wbt_cordic_cell u_cd1 (.i_clk(i_clk), .i_en(w_en), .i_stage(5'(k)),
                               .i_d(w_cd1[k]), .o_d(w_cd1[k+1]));
        wbt_cordic_cell u_cd2 (.i_clk(i_clk), .i_en(w_en), .i_stage(5'(k)),
                               .i_d(w_cd2[k]), .o_d(w_cd2[k+1]));
        wbt_cordic_cell u_cd3 (.i_clk(i_clk), .i_en(w_en), .i_stage(5'(k)),
                               .i_d(w_cd3[k]), .o_d(w_cd3[k+1]));
        wbt_cordic_cell u_cd4 (.i_clk(i_clk), .i_en(w_en), .i_stage(5'(k)),
                               .i_d(w_cd4[k]), .o_d(w_cd4[k+1]));
    end

    // products with the arctangents
    assign w_p1 = 43'(r_cd_side[CD].t16) * 43'(w_cd1[CD].z) + 43'sd32768;
    assign w_p4 = $signed({21'b0, r_cd_side[CD].c4}) * 41'(w_cd4[CD].z) + 41'sd32768;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_t1 <= w_p1[42:16];
            r_p_t4 <= w_p4[40:16];
            r_p_z2 <= w_cd2[CD].z;
            r_p_z3 <= w_cd3[CD].z;
            r_p_cl <= r_cd_side[CD].clamp;
        end
    end

    // sum, round, saturate
    assign w_sum = 28'(r_p_t1) + 28'(r_p_z2) - 28'(r_p_z3) + 28'(r_p_t4)
                 - $signed(wbt_pkg::C_BIAS);
    assign w_wb  = 20'((w_sum + 28'sd128) >>> 8);

    always_comb begin
        if (w_wb < wbt_pkg::WB_MIN) begin
            w_wb_sat = 15'(wbt_pkg::WB_MIN);
        end else if (w_wb > wbt_pkg::WB_MAX) begin
            w_wb_sat = 15'(wbt_pkg::WB_MAX);
        end else begin
            w_wb_sat = w_wb[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_wb <= w_wb_sat;
            r_out_hs <= (w_wb_sat >= r_thr);
            r_out_cl <= r_p_cl;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_wet_bulb_temp = r_out_wb;
    assign o_heat_stress   = r_out_hs;
    assign o_input_clamped = r_out_cl;

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge i_clk)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld[0] |-> (r_sq_side[0].rh16 >= 23'd327680 && r_sq_side[0].rh16 <= 23'd6488064))
        else $error("humidity outside clamp range");
    a_product_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cd_vld[CD] && w_en) |=> r_p_vld)
        else $error("item lost at product stage");
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(i_cfg_valid)) |-> (o_heat_stress == ($signed(o_wet_bulb_temp) >= r_thr)))
        else $error("stress flag disagrees with threshold");
`endif
endmodule
`default_nettype wire

// ===== hdl/wbt_sqrt_cell.sv =====
// One cell of the integer square root chain: one root bit per cell.
// Depends on wbt_pkg.
`default_nettype none
module wbt_sqrt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire wbt_pkg::t_sqrt i_d,
    output wbt_pkg::t_sqrt     o_d
);
    logic [22:0]    w_shift;
    logic [22:0]    w_trial;
    wbt_pkg::t_sqrt n_d;
    wbt_pkg::t_sqrt r_d;

    assign w_shift = {i_d.rem[20:0], i_d.rad[39:38]};
    assign w_trial = {1'b0, i_d.root, 2'b01};

    always_comb begin
        n_d.rad = {i_d.rad[37:0], 2'b00};
        if (w_shift >= w_trial) begin
            n_d.rem  = w_shift - w_trial;
            n_d.root = {i_d.root[18:0], 1'b1};
        end else begin
            n_d.rem  = w_shift;
            n_d.root = {i_d.root[18:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== hdl/wbt_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation for the arctangent chains.
// Depends on wbt_pkg.
`default_nettype none
module wbt_cordic_cell (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [4:0]       i_stage,
    input  wire wbt_pkg::t_cordic i_d,
    output wbt_pkg::t_cordic      o_d
);
    logic signed [31:0] w_dx;
    logic signed [31:0] w_dy;
    logic signed [19:0] w_ang;
    wbt_pkg::t_cordic   n_d;
    wbt_pkg::t_cordic   r_d;

    assign w_dx  = i_d.y >>> i_stage;
    assign w_dy  = i_d.x >>> i_stage;
    assign w_ang = $signed({3'b000, wbt_pkg::atan_q16(i_stage)});

    always_comb begin
        if (!i_d.y[31]) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + w_ang;
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the wet-bulb temperature estimator.
// Drives air temperature / humidity items, predicts each result in fixed point
// and compares it field by field. Depends on wbt_pkg and the top level RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 41;

    typedef struct {
        logic [14:0] wb;
        logic        stress;
        logic        clamped;
    } t_wb_result;

    typedef struct {
        logic [14:0] temp;
        logic [14:0] rh;
        logic        known;
        logic [14:0] wb;
        logic        stress;
        logic        clamped;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [14:0] i_air_temp = '0;
    logic [14:0] i_rel_humidity = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [14:0] o_wet_bulb_temp;
    logic        o_heat_stress;
    logic        o_input_clamped;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_stress_threshold = '0;

    wet_bulb_temperature_estimator u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_air_temp             (i_air_temp),
        .i_rel_humidity         (i_rel_humidity),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_wet_bulb_temp        (o_wet_bulb_temp),
        .o_heat_stress          (o_heat_stress),
        .o_input_clamped        (o_input_clamped),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_stress_threshold (i_cfg_stress_threshold)
    );

    t_wb_result       pending_wb[$];
    logic signed [14:0] threshold_q88;
    int               n_errors = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint v);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint arctan_q16(longint a);
        longint x = 65536;
        longint y = a;
        longint z = 0;
        longint dx, dy;
        for (int i = 0; i < wbt_pkg::ATAN_STAGES && i < 32; i++) begin
            dx = fl_shift(y, i);
            dy = fl_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(wbt_pkg::atan_q16(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(wbt_pkg::atan_q16(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic t_wb_result wet_bulb_of(logic [14:0] temp_in, logic [14:0] rh_in);
        t_wb_result r;
        longint t, rh, t16, rh16, sq1, a1, term1, term2, term3, sqr, r15, c4, a4, term4;
        longint sum, wb;
        t = longint'($signed(temp_in));
        rh = longint'(rh_in);
        r.clamped = 1'b0;
        if (t < -5120) begin t = -5120; r.clamped = 1'b1; end
        if (t > 12800) begin t = 12800; r.clamped = 1'b1; end
        if (rh < 1280) begin rh = 1280; r.clamped = 1'b1; end
        if (rh > 25344) begin rh = 25344; r.clamped = 1'b1; end
        t16 = t * 256;
        rh16 = rh * 256;
        sq1 = root_floor((rh16 + 544844) <<< 16);
        a1 = (sq1 * 2549751 + (64'sd1 <<< 23)) >>> 24;
        term1 = fl_shift(t16 * arctan_q16(a1) + 32768, 16);
        term2 = arctan_q16(t16 + rh16);
        term3 = arctan_q16(rh16 - 109860);
        sqr = root_floor(rh16 <<< 16);
        r15 = (rh16 * sqr + 32768) >>> 16;
        c4 = (r15 * 65740 + (64'sd1 <<< 23)) >>> 24;
        a4 = (rh16 * 387570 + (64'sd1 <<< 23)) >>> 24;
        term4 = fl_shift(c4 * arctan_q16(a4) + 32768, 16);
        sum = term1 + term2 - term3 + term4 - 307104;
        wb = fl_shift(sum + 128, 8);
        if (wb < -8192) wb = -8192;
        if (wb > 16383) wb = 16383;
        r.wb = wb[14:0];
        r.stress = (wb >= longint'(threshold_q88));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        i_air_temp <= 15'($urandom);
        i_rel_humidity <= 15'($urandom);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n != 0) begin
            drop_valid();
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_item(logic [14:0] temp, logic [14:0] rh, bit known, t_wb_result want);
        t_wb_result p;
        p = wet_bulb_of(temp, rh);
        if (known && (p.wb !== want.wb || p.stress !== want.stress
                || p.clamped !== want.clamped))
            report_mismatch("table row", int'($signed(p.wb)), int'($signed(want.wb)));
        i_in_valid <= 1'b1;
        i_air_temp <= temp;
        i_rel_humidity <= rh;
        pending_wb.push_back(p);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_and_write(logic signed [14:0] thr);
        drop_valid();
        while (pending_wb.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_stress_threshold <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        threshold_q88 = thr;
    endtask

    task automatic random_items(int n);
        logic [14:0] t, rh;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: begin t = 15'($urandom); rh = 15'($urandom); end
                1: begin t = 15'($urandom_range(0, 32767)); rh = 15'($urandom_range(0, 1279)); end
                default: begin
                    t = 15'($urandom_range(0, 17920) - 5120);
                    rh = 15'($urandom_range(1280, 25344));
                end
            endcase
            send_item(t, rh, 1'b0, '{default: 0});
            if ($urandom_range(0, 3) == 0) begin
                idle_gap();
            end
        end
    endtask

    t_stim_row rows[] = '{
        '{15'sd0,      15'd1280,  1'b0, 15'd0,     1'b0, 1'b0},
        '{-15'sd5120,  15'd1280,  1'b0, 15'd0,     1'b0, 1'b0},
        '{15'sd12800,  15'd25344, 1'b0, 15'd0,     1'b0, 1'b0},
        '{-15'sd5120,  15'd25344, 1'b0, 15'd0,     1'b0, 1'b0},
        '{15'sd12800,  15'd1280,  1'b0, 15'd0,     1'b0, 1'b0},
        '{-15'sd16384, 15'd0,     1'b0, 15'd0,     1'b0, 1'b1},
        '{15'sd16383,  15'd32767, 1'b0, 15'd0,     1'b1, 1'b1},
        '{-15'sd5121,  15'd6400,  1'b0, 15'd0,     1'b0, 1'b1},
        '{15'sd12801,  15'd6400,  1'b0, 15'd0,     1'b0, 1'b1},
        '{15'sd5120,   15'd1279,  1'b0, 15'd0,     1'b0, 1'b1},
        '{15'sd5120,   15'd25345, 1'b0, 15'd0,     1'b0, 1'b1},
        '{15'sd7680,   15'd12800, 1'b0, 15'd0,     1'b0, 1'b0},
        '{15'sd8960,   15'd23040, 1'b0, 15'd0,     1'b0, 1'b0},
        '{15'sd2560,   15'd17920, 1'b0, 15'd0,     1'b0, 1'b0},
        '{15'h2AAA,    15'h5555,  1'b0, 15'd0,     1'b0, 1'b1},
        '{15'h5555,    15'h2AAA,  1'b0, 15'd0,     1'b0, 1'b1}
    };

    always @(posedge i_clk) begin
        t_wb_result w;
        if (i_rst_n) begin
            if ($urandom_range(0, 5) == 0)
                i_out_stall <= ($urandom_range(0, 7) != 0);
            else if ($urandom_range(0, 3) == 0)
                i_out_stall <= 1'b0;
            if (o_out_valid && !i_out_stall) begin
                if (pending_wb.size() == 0) begin
                    report_mismatch("unexpected item", int'($signed(o_wet_bulb_temp)), 0);
                end else begin
                    w = pending_wb.pop_front();
                    if (o_wet_bulb_temp !== w.wb)
                        report_mismatch("wet_bulb_temp", int'($signed(o_wet_bulb_temp)),
                                        int'($signed(w.wb)));
                    if (o_heat_stress !== w.stress)
                        report_mismatch("heat_stress", int'(o_heat_stress), int'(w.stress));
                    if (o_input_clamped !== w.clamped)
                        report_mismatch("input_clamped", int'(o_input_clamped), int'(w.clamped));
                end
            end
        end
    end

    initial begin
        t_wb_result want;
        threshold_q88 = wbt_pkg::THR_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) begin
            want.wb = rows[k].wb;
            want.stress = rows[k].stress;
            want.clamped = rows[k].clamped;
            send_item(rows[k].temp, rows[k].rh, rows[k].known, want);
        end
        // clamped extremes and default threshold: outputs are fixed
        want = wet_bulb_of(15'sd12800, 15'd25344);
        want.clamped = 1'b1;
        send_item(15'sd16383, 15'd32767, 1'b1, want);
        random_items(150);
        drain_and_write(-15'sd8192);
        random_items(150);
        drain_and_write(15'sd16383);
        random_items(100);
        drain_and_write(15'sd3840);
        random_items(150);
        drain_and_write(15'($urandom_range(0, 8000)));
        random_items(80);
        drop_valid();
        while (pending_wb.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
